// File: hw/rtl/bitmap_set_bit_indexer_unit_assert.svh
`ifndef BITMAP_SET_BIT_INDEXER_UNIT_ASSERT_SVH
`define BITMAP_SET_BIT_INDEXER_UNIT_ASSERT_SVH

// check a property on every clock edge, reset included
`define BSBI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// check a property outside reset
`define BSBI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: hw/rtl/bsbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsbi_pkg;

   localparam int MAX_BITS   = 65536;
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int WORD_NUM_W = $clog2(MAX_BITS / WORD_BITS);
   localparam int NWORDS_W   = WORD_NUM_W + 1;
   localparam int LEN_W      = 17;
   localparam int INDEX_W    = 32;
   localparam int VALID_W    = WORD_SHIFT + 1;
   localparam int CSR_W      = 32;

   localparam logic CSR_LENGTH_BITS = 1'b0;
   localparam logic CSR_BASE_OFFSET = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic bit0;
      logic last;
      logic out_free;
   } sts_type;

   function automatic word_type low_mask(input logic [VALID_W-1:0] n);
      word_type m;
      for (int i = 0; i < WORD_BITS; i++) begin
         m[i] = (VALID_W'(i) < n);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_set_bit_indexer_unit.sv
// Set-bit index enumerator for a bitmap streamed one 32-bit word at a time.
// req channel: one bitmap word per transfer, lowest word of the bitmap first.
// rsp channel: one word per set bit, lowest bit first; tdata is the bit index
// (word number * 32 + bit position + base offset, mod 2^32), tlast marks the
// last index of an input word. An all-zero word yields nothing.
// csr port: index 0 writes length_bits, index 1 writes the base offset; write
// only while no word is in flight.
// Flow: an accepted word is loaded into the bit scanner, and each index is then
// registered in the output register. The bit scanner walks one bit per cycle,
// pausing at a set bit while the output register cannot take an index, and
// stops after the highest counted set bit. The next word is taken once the last
// index has been loaded into the output register.
// Reset: length_bits returns to 65536, the base offset and the word counter
// to 0, and the output register is emptied.
// Stall: while rsp_tready is low the output register holds its word and the
// scanner waits at the next set bit.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_bit_indexer_unit
   import bsbi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [WORD_BITS-1:0] req_tdata,  // [31:0] bitmap_word
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [INDEX_W-1:0]      rsp_tdata,    // [31:0] bit_index
   output logic                    rsp_tlast     // last_of_word
);

   cmd_type cmd;
   sts_type sts;

   bsbi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bsbi_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: hw/rtl/bsbi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsbi_ctrl
   import bsbi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (sts.empty) begin
               state_in = ST_IDLE;
            end else if (sts.bit0 && sts.out_free && sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            priority if (sts.empty) begin
               cmd = '0;
            end else if (!sts.bit0) begin
               cmd.shift = 1'b1;
            end else if (sts.out_free) begin
               cmd.shift = 1'b1;
               cmd.emit  = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bsbi_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bsbi_dpath
   import bsbi_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire word_type         req_tdata,
   input  wire cmd_type          cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [INDEX_W-1:0]    rsp_tdata,
   output logic                  rsp_tlast
);

   logic [LEN_W-1:0]      length_ff;
   logic [INDEX_W-1:0]    offset_ff;
   logic [WORD_NUM_W-1:0] word_num_ff;
   logic [WORD_NUM_W-1:0] word_num_in;
   word_type              shreg_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic                  rsp_last_ff;

   logic [LEN_W-1:0]      len_clamp;
   logic [LEN_W:0]        len_round;
   logic [NWORDS_W-1:0]   nwords;
   logic [WORD_SHIFT-1:0] rem;
   logic [VALID_W-1:0]    valid_cnt;
   logic                  final_word;
   word_type              word_mask;
   logic [INDEX_W-1:0]    base;

   always_comb begin
      len_clamp = (length_ff > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : length_ff;
      len_round = {1'b0, len_clamp} + (LEN_W + 1)'(WORD_BITS - 1);
      nwords    = len_round[WORD_SHIFT +: NWORDS_W];
      rem       = len_clamp[WORD_SHIFT-1:0];
      if (nwords == '0) begin
         final_word = 1'b1;
         valid_cnt  = '0;
      end else begin
         final_word = ({1'b0, word_num_ff} >= (nwords - NWORDS_W'(1)));
         valid_cnt  = (rem == '0) ? VALID_W'(WORD_BITS) : {1'b0, rem};
      end
      word_mask   = final_word ? low_mask(valid_cnt) : '1;
      base        = INDEX_W'({word_num_ff, {WORD_SHIFT{1'b0}}}) + offset_ff;
      word_num_in = final_word ? '0 : word_num_ff + WORD_NUM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(MAX_BITS);
         offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LENGTH_BITS: length_ff <= csr_wdata[LEN_W-1:0];
            CSR_BASE_OFFSET: offset_ff <= csr_wdata[INDEX_W-1:0];
            default:         offset_ff <= offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_num_ff <= '0;
         shreg_ff    <= '0;
      end else if (cmd.load) begin
         word_num_ff <= word_num_in;
         shreg_ff    <= req_tdata & word_mask;
      end else if (cmd.shift) begin
         shreg_ff    <= shreg_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= base;
      end else if (cmd.shift) begin
         idx_ff <= idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index_ff <= idx_ff;
         rsp_last_ff  <= sts.last;
      end
   end

   always_comb begin
      sts.empty    = (shreg_ff == '0);
      sts.bit0     = shreg_ff[0];
      sts.last     = (shreg_ff[WORD_BITS-1:1] == '0);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bsbi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_set_bit_indexer_unit_assert.svh"

module bsbi_checker
   import bsbi_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [INDEX_W-1:0] rsp_tdata,
   input wire logic               rsp_tlast
);

   `BSBI_ASSERT_ALWAYS(a_reset_state, reset |=> (!rsp_tvalid && req_tready),
                       "bad state after reset")

   `BSBI_ASSERT(a_rsp_hold,
                (rsp_tvalid && !rsp_tready) |=>
                   (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)),
                "rsp word changed under stall")

   `BSBI_ASSERT(a_busy_after_accept, (req_tvalid && req_tready) |=> !req_tready,
                "word accepted while scanning")

   `BSBI_ASSERT(a_busy_mid_word, (rsp_tvalid && !rsp_tlast) |-> !req_tready,
                "new word taken before last index")

endmodule

bind bitmap_set_bit_indexer_unit bsbi_checker u_bsbi_checker (.*);

`default_nettype wire
